// File: rtl/rae_pkg.sv
// ----------------------------------------------------------------------------
// rae_pkg
// shared constants, codes and controller/datapath interface types for the
// register alu execute block
// ----------------------------------------------------------------------------
package rae_pkg;

   localparam int REG_COUNT       = 32;
   localparam int INDEX_WIDTH     = $clog2(REG_COUNT);
   localparam int DATA_WIDTH      = 32;
   localparam int SHAMT_WIDTH     = 5;
   localparam int DIV_COUNT_WIDTH = $clog2(DATA_WIDTH);
   localparam logic [DIV_COUNT_WIDTH-1:0] DIV_LAST = DIV_COUNT_WIDTH'(DATA_WIDTH - 1);

   // instruction types
   localparam logic ACTION_REG = 1'b0;
   localparam logic ACTION_IMM = 1'b1;

   // operation codes
   localparam logic [7:0] OP_ADD  = 8'h01;
   localparam logic [7:0] OP_SUB  = 8'h02;
   localparam logic [7:0] OP_AND  = 8'h03;
   localparam logic [7:0] OP_OR   = 8'h04;
   localparam logic [7:0] OP_XOR  = 8'h05;
   localparam logic [7:0] OP_SLL  = 8'h06;
   localparam logic [7:0] OP_SRL  = 8'h07;
   localparam logic [7:0] OP_SRA  = 8'h08;
   localparam logic [7:0] OP_MUL  = 8'h09;
   localparam logic [7:0] OP_DIV  = 8'h0A;
   localparam logic [7:0] OP_REM  = 8'h0B;
   localparam logic [7:0] OP_GAP  = 8'h0C;
   localparam logic [7:0] OP_MOV  = 8'h0D;
   localparam logic [7:0] OP_NOT  = 8'h0E;
   localparam logic [7:0] OP_NEG  = 8'h0F;
   localparam logic [7:0] OP_ADDI = 8'h10;
   localparam logic [7:0] OP_SUBI = 8'h11;
   localparam logic [7:0] OP_ANDI = 8'h12;

   typedef enum logic [1:0] {
      STATUS_WRITTEN   = 2'd0,
      STATUS_UNHANDLED = 2'd1,
      STATUS_DIV_ZERO  = 2'd2
   } status_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic div_start;
      logic div_step;
      logic div_finish;
      logic commit;
   } ctrl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic need_div;
      logic div_last;
   } dp_status_type;

endpackage

// File: rtl/rae_regfile.sv
// ----------------------------------------------------------------------------
// rae_regfile
// general register file, one write port and two registered read ports,
// per-entry valid bits so that reset reads back as zero
// ----------------------------------------------------------------------------
module rae_regfile
   import rae_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rd_en,
   input  logic [INDEX_WIDTH-1:0] rd1_index,
   input  logic [INDEX_WIDTH-1:0] rd2_index,
   output logic [DATA_WIDTH-1:0]  rd1_data,
   output logic [DATA_WIDTH-1:0]  rd2_data,
   input  logic                   wr_en,
   input  logic [INDEX_WIDTH-1:0] wr_index,
   input  logic [DATA_WIDTH-1:0]  wr_data
);

   logic [DATA_WIDTH-1:0] reg_mem_ff [REG_COUNT];
   logic [REG_COUNT-1:0]  valid_ff;
   logic [REG_COUNT-1:0]  valid_in;
   logic [DATA_WIDTH-1:0] rd1_data_ff;
   logic [DATA_WIDTH-1:0] rd2_data_ff;
   logic                  rd1_valid_ff;
   logic                  rd2_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_index] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         reg_mem_ff[wr_index] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd1_data_ff  <= reg_mem_ff[rd1_index];
         rd2_data_ff  <= reg_mem_ff[rd2_index];
         rd1_valid_ff <= valid_ff[rd1_index];
         rd2_valid_ff <= valid_ff[rd2_index];
      end
   end

   // never-written entries read as zero
   assign rd1_data = rd1_valid_ff ? rd1_data_ff : '0;
   assign rd2_data = rd2_valid_ff ? rd2_data_ff : '0;

endmodule

// File: rtl/rae_datapath.sv
// ----------------------------------------------------------------------------
// rae_datapath
// operand capture, alu, iterative signed divider, result and response
// registers, register file
// ----------------------------------------------------------------------------
module rae_datapath
   import rae_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_cmd_type           cmd,
   output dp_status_type          status,
   input  logic                   req_action,
   input  logic [7:0]             req_opcode,
   input  logic [INDEX_WIDTH-1:0] req_dest_index,
   input  logic [INDEX_WIDTH-1:0] req_src1_index,
   input  logic [INDEX_WIDTH-1:0] req_src2_index,
   input  logic signed [31:0]     req_immediate,
   output logic [1:0]             rsp_status,
   output logic [INDEX_WIDTH-1:0] rsp_written_index,
   output logic [DATA_WIDTH-1:0]  rsp_written_value
);

   logic                       action_ff, action_in;
   logic [7:0]                 opcode_ff, opcode_in;
   logic [INDEX_WIDTH-1:0]     dest_ff, dest_in;
   logic [DATA_WIDTH-1:0]      imm_ff, imm_in;
   logic [DATA_WIDTH-1:0]      result_ff, result_in;
   status_type                 status_ff, status_in;
   logic [DATA_WIDTH-1:0]      rem_ff, rem_in;
   logic [DATA_WIDTH-1:0]      quo_ff, quo_in;
   logic [DATA_WIDTH-1:0]      dvs_ff, dvs_in;
   logic                       neg_quo_ff, neg_quo_in;
   logic                       neg_rem_ff, neg_rem_in;
   logic                       want_rem_ff, want_rem_in;
   logic [DIV_COUNT_WIDTH-1:0] div_count_ff, div_count_in;
   status_type                 rsp_status_ff, rsp_status_in;
   logic [INDEX_WIDTH-1:0]     rsp_index_ff, rsp_index_in;
   logic [DATA_WIDTH-1:0]      rsp_value_ff, rsp_value_in;

   logic [DATA_WIDTH-1:0] op_a;
   logic [DATA_WIDTH-1:0] op_b;
   logic [DATA_WIDTH-1:0] product;
   logic [DATA_WIDTH-1:0] exec_value;
   status_type            exec_status;
   logic                  exec_need_div;
   logic                  handled;
   logic [DATA_WIDTH:0]   div_shifted;
   logic [DATA_WIDTH:0]   div_diff;
   logic                  rf_wr_en;

   rae_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (cmd.capture),
      .rd1_index (req_src1_index),
      .rd2_index (req_src2_index),
      .rd1_data  (op_a),
      .rd2_data  (op_b),
      .wr_en     (rf_wr_en),
      .wr_index  (dest_ff),
      .wr_data   (result_ff)
   );

   assign product = op_a * op_b;

   always_comb begin
      if (opcode_ff >= OP_OR && opcode_ff <= OP_NEG && opcode_ff != OP_GAP) begin
         handled = 1'b1;
      end else if (action_ff == ACTION_REG) begin
         handled = (opcode_ff >= OP_ADD) && (opcode_ff <= OP_AND);
      end else begin
         handled = (opcode_ff >= OP_ADDI) && (opcode_ff <= OP_ANDI);
      end
   end

   always_comb begin
      exec_value    = '0;
      exec_status   = STATUS_WRITTEN;
      exec_need_div = 1'b0;
      priority if (!handled) begin
         exec_status = STATUS_UNHANDLED;
      end else if (dest_ff == '0) begin
         exec_value = '0;
      end else begin
         unique case (opcode_ff)
            OP_ADD:  exec_value = op_a + op_b;
            OP_SUB:  exec_value = op_a - op_b;
            OP_AND:  exec_value = op_a & op_b;
            OP_OR:   exec_value = op_a | op_b;
            OP_XOR:  exec_value = op_a ^ op_b;
            OP_SLL:  exec_value = op_a << op_b[SHAMT_WIDTH-1:0];
            OP_SRL:  exec_value = op_a >> op_b[SHAMT_WIDTH-1:0];
            OP_SRA:  exec_value = DATA_WIDTH'($signed(op_a) >>> op_b[SHAMT_WIDTH-1:0]);
            OP_MUL:  exec_value = product;
            OP_DIV, OP_REM: begin
               if (op_b == '0) begin
                  exec_status = STATUS_DIV_ZERO;
               end else begin
                  exec_need_div = 1'b1;
               end
            end
            OP_MOV:  exec_value = op_a;
            OP_NOT:  exec_value = ~op_a;
            OP_NEG:  exec_value = '0 - op_a;
            OP_ADDI: exec_value = op_a + imm_ff;
            OP_SUBI: exec_value = op_a - imm_ff;
            default: exec_value = op_a & imm_ff;
         endcase
      end
   end

   // one restoring step of the unsigned divider
   assign div_shifted = {rem_ff, quo_ff[DATA_WIDTH-1]};
   assign div_diff    = div_shifted - {1'b0, dvs_ff};

   always_comb begin
      action_in     = action_ff;
      opcode_in     = opcode_ff;
      dest_in       = dest_ff;
      imm_in        = imm_ff;
      result_in     = result_ff;
      status_in     = status_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      dvs_in        = dvs_ff;
      neg_quo_in    = neg_quo_ff;
      neg_rem_in    = neg_rem_ff;
      want_rem_in   = want_rem_ff;
      div_count_in  = div_count_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_value_in  = rsp_value_ff;

      if (cmd.capture) begin
         action_in = req_action;
         opcode_in = req_opcode;
         dest_in   = req_dest_index;
         imm_in    = DATA_WIDTH'($unsigned(req_immediate));
      end
      if (cmd.exec) begin
         result_in = exec_value;
         status_in = exec_status;
      end
      if (cmd.div_start) begin
         quo_in       = op_a[DATA_WIDTH-1] ? ('0 - op_a) : op_a;
         dvs_in       = op_b[DATA_WIDTH-1] ? ('0 - op_b) : op_b;
         rem_in       = '0;
         neg_quo_in   = op_a[DATA_WIDTH-1] ^ op_b[DATA_WIDTH-1];
         neg_rem_in   = op_a[DATA_WIDTH-1];
         want_rem_in  = (opcode_ff == OP_REM);
         div_count_in = '0;
      end
      if (cmd.div_step) begin
         if (!div_diff[DATA_WIDTH]) begin
            rem_in = div_diff[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = div_shifted[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b0};
         end
         div_count_in = div_count_ff + 1'b1;
      end
      if (cmd.div_finish) begin
         if (want_rem_ff) begin
            result_in = neg_rem_ff ? ('0 - rem_ff) : rem_ff;
         end else begin
            result_in = neg_quo_ff ? ('0 - quo_ff) : quo_ff;
         end
      end
      if (cmd.commit) begin
         rsp_status_in = status_ff;
         rsp_index_in  = dest_ff;
         rsp_value_in  = (status_ff == STATUS_WRITTEN) ? result_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      opcode_ff     <= opcode_in;
      dest_ff       <= dest_in;
      imm_ff        <= imm_in;
      result_ff     <= result_in;
      status_ff     <= status_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      dvs_ff        <= dvs_in;
      neg_quo_ff    <= neg_quo_in;
      neg_rem_ff    <= neg_rem_in;
      want_rem_ff   <= want_rem_in;
      div_count_ff  <= div_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rf_wr_en = cmd.commit && (status_ff == STATUS_WRITTEN);

   assign status.need_div = exec_need_div;
   assign status.div_last = (div_count_ff == DIV_LAST);

   assign rsp_status        = rsp_status_ff;
   assign rsp_written_index = rsp_index_ff;
   assign rsp_written_value = rsp_value_ff;

endmodule

// File: rtl/rae_control.sv
// ----------------------------------------------------------------------------
// rae_control
// sequencing state machine: accept, execute, divide, sign fix, commit, and
// the response valid flag
// ----------------------------------------------------------------------------
module rae_control
   import rae_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_EXEC   = 5'b00010,
      ST_DIVIDE = 5'b00100,
      ST_FIX    = 5'b01000,
      ST_WRITE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   // response slot can take a new transaction this cycle
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVIDE;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            cmd.div_finish = 1'b1;
            state_in       = ST_WRITE;
         end
         ST_WRITE: begin
            if (rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/register_alu_execute.sv
// ----------------------------------------------------------------------------
// register_alu_execute
// executes one register-type or immediate-type integer instruction at a time
// against a 32 x 32-bit register file and reports one result per transaction
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake             payload
//   req       in          req_valid/req_stall   action, opcode, dest/src1/src2
//                                               index, immediate
//   rsp       out         rsp_valid/rsp_stall   status, written_index,
//                                               written_value
//
// - a transaction runs from acceptance through capture with register read,
//   execute and commit; divide and remainder add the 32 steps of the
//   one-bit-per-cycle restoring divider and a sign-fix step before commit
// - one transaction at a time: req_stall is high from acceptance until the
//   result is committed to the response register
// - the response register frees the engine: the next transaction is taken
//   while a result still waits on rsp_stall; commit waits only if the slot
//   is still occupied
// - synchronous active-high reset clears the controller, the response valid
//   and the register file valid bits, so every register reads zero at once
//
module register_alu_execute
   import rae_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_action,
   input  logic [7:0]             req_opcode,
   input  logic [INDEX_WIDTH-1:0] req_dest_index,
   input  logic [INDEX_WIDTH-1:0] req_src1_index,
   input  logic [INDEX_WIDTH-1:0] req_src2_index,
   input  logic signed [31:0]     req_immediate,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_status,
   output logic [INDEX_WIDTH-1:0] rsp_written_index,
   output logic [DATA_WIDTH-1:0]  rsp_written_value
);

   // controller to datapath commands and datapath feedback
   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   // sequencing, handshakes and response valid
   rae_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (dp_status),
      .cmd       (cmd)
   );

   // register file, alu, divider and response payload
   rae_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (dp_status),
      .req_action        (req_action),
      .req_opcode        (req_opcode),
      .req_dest_index    (req_dest_index),
      .req_src1_index    (req_src1_index),
      .req_src2_index    (req_src2_index),
      .req_immediate     (req_immediate),
      .rsp_status        (rsp_status),
      .rsp_written_index (rsp_written_index),
      .rsp_written_value (rsp_written_value)
   );

endmodule

// File: sim/tb_register_alu_execute.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_register_alu_execute
// self-checking bench for the register alu execute block: a short table of
// directed instructions, then randomised instruction streams, every result
// compared field by field with its table entry or else a shadow register file kept in the bench
// ----------------------------------------------------------------------------
module tb_register_alu_execute;
   import rae_pkg::*;

   localparam int N_RANDOM    = 1820;  // random instructions after the table
   localparam int HOLD_AT     = 600;   // random item that starts the long hold-off
   localparam int PAUSE_AT    = 1100;  // random item before which the sender drains
   localparam int TAIL_ITEMS  = 250;   // last items run with no idling at all
   localparam int HOLD_CYCLES = 400;   // length of the receiver hold-off
   localparam int STALL_LIMIT = 2000;  // cycles with no transaction before giving up
   localparam int TAIL_CYCLES = 40;    // settle time after the last result

   typedef struct {
      logic                   action;
      logic [7:0]             opcode;
      logic [INDEX_WIDTH-1:0] dest;
      logic [INDEX_WIDTH-1:0] src1;
      logic [INDEX_WIDTH-1:0] src2;
      logic signed [31:0]     imm;
   } alu_instr_type;

   typedef struct {
      status_type             status;
      logic [INDEX_WIDTH-1:0] index;
      logic [DATA_WIDTH-1:0]  value;
   } alu_result_type;

   typedef struct {
      alu_instr_type  instr;
      bit             typed;   // expected result written into the table
      alu_result_type want;
   } dir_row_type;

   // dut connections, inputs all driven to known values from time zero
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_action = ACTION_REG;
   logic [7:0]             req_opcode = OP_ADD;
   logic [INDEX_WIDTH-1:0] req_dest_index = '0;
   logic [INDEX_WIDTH-1:0] req_src1_index = '0;
   logic [INDEX_WIDTH-1:0] req_src2_index = '0;
   logic signed [31:0]     req_immediate = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [1:0]             rsp_status;
   logic [INDEX_WIDTH-1:0] rsp_written_index;
   logic [DATA_WIDTH-1:0]  rsp_written_value;

   // bench state
   logic [DATA_WIDTH-1:0] shadow_regs [REG_COUNT];
   alu_result_type        pending_results [$];
   dir_row_type           directed_rows [$];
   int                    error_count     = 0;
   int                    instrs_sent     = 0;
   int                    results_checked = 0;
   int                    div_zero_seen   = 0;
   int                    unhandled_seen  = 0;
   bit                    hold_pending    = 1'b0;
   bit                    quiet_tail      = 1'b0;

   logic [7:0] op_menu [17] = '{OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_SLL, OP_SRL,
                                OP_SRA, OP_MUL, OP_DIV, OP_REM, OP_MOV, OP_NOT, OP_NEG,
                                OP_ADDI, OP_SUBI, OP_ANDI};
   logic [31:0] corner_values [5] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                                      32'h0000_0001, 32'h0000_0000};

   always #2 clock = ~clock;

   register_alu_execute u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_opcode        (req_opcode),
      .req_dest_index    (req_dest_index),
      .req_src1_index    (req_src1_index),
      .req_src2_index    (req_src2_index),
      .req_immediate     (req_immediate),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_written_index (rsp_written_index),
      .rsp_written_value (rsp_written_value)
   );

   task automatic report_error(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   // executes one instruction on the shadow register file and returns the
   // result the block should report for it
   function automatic alu_result_type execute_instr(alu_instr_type ins);
      logic [31:0]    a, b, val, mag_a, mag_b, quo, rem;
      logic           handled;
      alu_result_type res;
      // sources outside the file read as zero
      a = (int'(ins.src1) < REG_COUNT) ? shadow_regs[ins.src1] : '0;
      b = (int'(ins.src2) < REG_COUNT) ? shadow_regs[ins.src2] : '0;
      val = '0;
      res.status = STATUS_WRITTEN;
      res.index  = ins.dest;
      // or .. neg (minus the gap code) are shared by both types
      case (ins.opcode)
         OP_OR, OP_XOR, OP_SLL, OP_SRL, OP_SRA, OP_MUL, OP_DIV, OP_REM,
         OP_MOV, OP_NOT, OP_NEG:    handled = 1'b1;
         OP_ADD, OP_SUB, OP_AND:    handled = (ins.action == ACTION_REG);
         OP_ADDI, OP_SUBI, OP_ANDI: handled = (ins.action == ACTION_IMM);
         default:                   handled = 1'b0;
      endcase
      if (!handled || int'(ins.dest) >= REG_COUNT) begin
         res.status = STATUS_UNHANDLED;
      end else if (ins.dest == '0) begin
         // destination zero wins over all but an unhandled code, divide by zero included
         shadow_regs[0] = '0;
      end else begin
         case (ins.opcode)
            OP_ADD:  val = a + b;
            OP_SUB:  val = a - b;
            OP_AND:  val = a & b;
            OP_OR:   val = a | b;
            OP_XOR:  val = a ^ b;
            OP_SLL:  val = a << b[4:0];
            OP_SRL:  val = a >> b[4:0];
            OP_SRA:  val = $signed(a) >>> b[4:0];
            OP_MUL:  val = a * b;
            OP_DIV, OP_REM: begin
               if (b == '0) begin
                  res.status = STATUS_DIV_ZERO;
               end else begin
                  // magnitudes, then quotient toward zero and remainder
                  // with the sign of the dividend; min / -1 wraps to min
                  mag_a = a[31] ? -a : a;
                  mag_b = b[31] ? -b : b;
                  quo   = mag_a / mag_b;
                  rem   = mag_a % mag_b;
                  if (ins.opcode == OP_REM) val = a[31] ? -rem : rem;
                  else                      val = (a[31] ^ b[31]) ? -quo : quo;
               end
            end
            OP_MOV:  val = a;
            OP_NOT:  val = ~a;
            OP_NEG:  val = -a;
            OP_ADDI: val = a + ins.imm;
            OP_SUBI: val = a - ins.imm;
            default: val = a & ins.imm;
         endcase
         if (res.status == STATUS_WRITTEN) shadow_regs[ins.dest] = val;
      end
      res.value = (res.status == STATUS_WRITTEN) ? val : '0;
      return res;
   endfunction

   function automatic void add_row(logic action, logic [7:0] opcode, int dest, int src1,
                                   int src2, logic [31:0] imm, int typed = 0,
                                   status_type status = STATUS_WRITTEN,
                                   logic [31:0] value = '0);
      dir_row_type row;
      row.instr.action = action;
      row.instr.opcode = opcode;
      row.instr.dest   = dest[INDEX_WIDTH-1:0];
      row.instr.src1   = src1[INDEX_WIDTH-1:0];
      row.instr.src2   = src2[INDEX_WIDTH-1:0];
      row.instr.imm    = imm;
      row.typed        = (typed != 0);
      row.want.status  = status;
      row.want.index   = dest[INDEX_WIDTH-1:0];
      row.want.value   = value;
      directed_rows.push_back(row);
   endfunction

   // offers one instruction at a falling edge, optionally after a gap, and
   // holds it until the block takes it; returns just after that rising edge
   task automatic send_instr(alu_instr_type ins, bit typed, alu_result_type want, int gap);
      alu_result_type res;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= ins.action;
      req_opcode     <= ins.opcode;
      req_dest_index <= ins.dest;
      req_src1_index <= ins.src1;
      req_src2_index <= ins.src2;
      req_immediate  <= ins.imm;
      do @(posedge clock); while (req_stall);
      // the shadow file always advances, typed rows only replace the answer
      res = execute_instr(ins);
      if (typed) res = want;
      if (res.status == STATUS_DIV_ZERO)  div_zero_seen++;
      if (res.status == STATUS_UNHANDLED) unhandled_seen++;
      pending_results.push_back(res);
      instrs_sent++;
   endtask

   // sender goes quiet until every outstanding result has come back
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // result checker: oldest expectation against each accepted transaction
   always @(posedge clock) begin : check_results
      alu_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_error($sformatf("result with nothing outstanding: status %0d index %0d value %h",
                                   rsp_status, rsp_written_index, rsp_written_value));
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_status !== want.status)
               report_error($sformatf("result %0d status %0d, expected %0d",
                                      results_checked, rsp_status, want.status));
            if (rsp_written_index !== want.index)
               report_error($sformatf("result %0d index %0d, expected %0d",
                                      results_checked, rsp_written_index, want.index));
            if (rsp_written_value !== want.value)
               report_error($sformatf("result %0d value %h, expected %h",
                                      results_checked, rsp_written_value, want.value));
         end
      end
   end

   // receiver: random stall bursts, calm stretches, one long hold-off on request
   initial begin : response_sink
      int burst_left;
      int hold_left;
      int cycle_count;
      bit calm;
      bit hold_taken;
      burst_left  = 0;
      hold_left   = 0;
      cycle_count = 0;
      calm        = 1'b0;
      hold_taken  = 1'b0;
      forever begin
         @(negedge clock);
         if (cycle_count % 200 == 0) calm = ($urandom_range(0, 3) == 0);
         cycle_count++;
         if (hold_pending && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (quiet_tail || calm) begin
            rsp_stall <= 1'b0;
         end else if (burst_left > 0) begin
            rsp_stall <= 1'b1;
            burst_left--;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 5) == 0) burst_left = $urandom_range(1, 16);
         end
      end
   end

   // no transaction on either channel for too long means the block is stuck
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("timeout: no transaction for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_results.size());
      $display("FAIL register_alu_execute");
      $finish;
   end

   initial begin : stimulus
      alu_instr_type  ins;
      alu_result_type none;
      int             gap;
      int             pick;
      int             no_gap_left;
      bit             send_calm;
      no_gap_left = 0;
      send_calm   = 1'b0;
      none.status = STATUS_WRITTEN;
      none.index  = '0;
      none.value  = '0;
      foreach (shadow_regs[i]) shadow_regs[i] = '0;

      // directed table: corner loads first, then every operation on them
      add_row(ACTION_IMM, OP_ADDI,  1,  0,  0, 32'h7FFF_FFFF, 1, STATUS_WRITTEN, 32'h7FFF_FFFF);
      add_row(ACTION_IMM, OP_ADDI,  2,  0,  0, 32'h8000_0000, 1, STATUS_WRITTEN, 32'h8000_0000);
      add_row(ACTION_IMM, OP_SUBI, 31,  0,  0, 32'h0000_0001, 1, STATUS_WRITTEN, 32'hFFFF_FFFF);
      add_row(ACTION_IMM, OP_ADDI, 19,  0,  0, 32'hFFFF_FFF9, 1, STATUS_WRITTEN, 32'hFFFF_FFF9);
      add_row(ACTION_IMM, OP_ADDI, 20,  0,  0, 32'h0000_0002, 1, STATUS_WRITTEN, 32'h0000_0002);
      add_row(ACTION_REG, OP_ADD,   5,  1,  1, 32'h0);
      add_row(ACTION_REG, OP_SUB,   6,  2,  1, 32'h0);
      add_row(ACTION_REG, OP_AND,   7,  1, 31, 32'h0);
      add_row(ACTION_REG, OP_OR,    8,  2, 20, 32'h0);
      add_row(ACTION_IMM, OP_XOR,   9,  1, 31, 32'h5A5A_5A5A);
      add_row(ACTION_REG, OP_SLL,  10, 31,  1, 32'h0);
      add_row(ACTION_REG, OP_SRL,  11,  2, 19, 32'h0);
      add_row(ACTION_IMM, OP_SRA,  12,  2, 20, 32'h0);
      add_row(ACTION_REG, OP_MUL,  13,  1,  1, 32'h0);
      add_row(ACTION_IMM, OP_ANDI,  4, 31,  0, 32'h0000_FFFF);
      // divide by zero, and destination zero masking it
      add_row(ACTION_REG, OP_DIV,  14, 19,  0, 32'h0, 1, STATUS_DIV_ZERO, 32'h0);
      add_row(ACTION_IMM, OP_REM,  15, 19,  0, 32'h0, 1, STATUS_DIV_ZERO, 32'h0);
      add_row(ACTION_REG, OP_DIV,   0, 19,  0, 32'h0, 1, STATUS_WRITTEN, 32'h0);
      // most negative over minus one, then truncation and remainder sign
      add_row(ACTION_REG, OP_DIV,  16,  2, 31, 32'h0, 1, STATUS_WRITTEN, 32'h8000_0000);
      add_row(ACTION_REG, OP_REM,  17,  2, 31, 32'h0, 1, STATUS_WRITTEN, 32'h0);
      add_row(ACTION_REG, OP_DIV,  18, 19, 20, 32'h0, 1, STATUS_WRITTEN, 32'hFFFF_FFFD);
      add_row(ACTION_IMM, OP_REM,  21, 19, 20, 32'h0, 1, STATUS_WRITTEN, 32'hFFFF_FFFF);
      add_row(ACTION_REG, OP_MOV,  22, 19,  0, 32'h0);
      add_row(ACTION_IMM, OP_NOT,  23, 19,  0, 32'h0);
      add_row(ACTION_REG, OP_NEG,  24,  2,  0, 32'h0);
      // opcodes the type does not handle, then an immediate add to destination zero
      add_row(ACTION_REG, OP_ADDI, 25,  1,  1, 32'h1, 1, STATUS_UNHANDLED, 32'h0);
      add_row(ACTION_IMM, OP_SUB,  26,  1,  1, 32'h0, 1, STATUS_UNHANDLED, 32'h0);
      add_row(ACTION_REG, OP_GAP,  27,  1,  1, 32'h0, 1, STATUS_UNHANDLED, 32'h0);
      add_row(ACTION_IMM, OP_ADDI,  0,  1,  0, 32'hFFFF_FFFF, 1, STATUS_WRITTEN, 32'h0);

      // synchronous reset, released at a falling edge
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
         send_instr(directed_rows[i].instr, directed_rows[i].typed, directed_rows[i].want, gap);
      end

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n % 100 == 0) send_calm = ($urandom_range(0, 3) == 0);
         if (n == N_RANDOM - TAIL_ITEMS) quiet_tail = 1'b1;
         // receiver holds off while the sender keeps pushing back to back
         if (n == HOLD_AT) begin
            hold_pending = 1'b1;
            no_gap_left  = 40;
         end
         if (n == PAUSE_AT) drain_results();

         ins.action = 1'($urandom_range(0, 1));
         ins.dest   = INDEX_WIDTH'($urandom_range(0, 31));
         ins.src1   = INDEX_WIDTH'($urandom_range(0, 31));
         ins.src2   = INDEX_WIDTH'($urandom_range(0, 31));
         ins.imm    = $urandom;
         pick       = $urandom_range(0, 99);
         if (pick < 8) begin
            // noise: any code under any type
            ins.opcode = 8'($urandom_range(0, 255));
         end else if (pick < 18) begin
            // load a corner value so divide overflow and sign cases turn up
            ins.action = ACTION_IMM;
            ins.opcode = pick[0] ? OP_ADDI : OP_SUBI;
            ins.src1   = '0;
            ins.imm    = corner_values[$urandom_range(0, 4)];
         end else begin
            ins.opcode = op_menu[$urandom_range(0, 16)];
            case (ins.opcode)
               OP_ADD, OP_SUB, OP_AND:    ins.action = ACTION_REG;
               OP_ADDI, OP_SUBI, OP_ANDI: ins.action = ACTION_IMM;
               default: ;
            endcase
            if ((ins.opcode == OP_DIV || ins.opcode == OP_REM) && $urandom_range(0, 7) == 0)
               ins.src2 = '0;
            if ($urandom_range(0, 7) == 0) ins.imm = corner_values[$urandom_range(0, 4)];
         end

         gap = 0;
         if (no_gap_left > 0) no_gap_left--;
         else if (!send_calm && !quiet_tail && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 16);
         send_instr(ins, 1'b0, none, gap);
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("ran %0d instructions (%0d directed), checked %0d results",
               instrs_sent, directed_rows.size(), results_checked);
      $display("%0d divide by zero, %0d unhandled, %0d-cycle receiver hold-off, %0d errors",
               div_zero_seen, unhandled_seen, HOLD_CYCLES, error_count);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("PASS register_alu_execute");
      end else begin
         $display("FAIL register_alu_execute");
      end
      $finish;
   end

endmodule
